// ===== hdl/led_bpt_pkg.sv =====
`timescale 1ns / 1ps

package led_bpt_pkg;

	// APB byte address width: five 32-bit registers at 4*i
	localparam int ADDR_W = 5;

	// pin level that lights the LED after reset
	localparam logic ACTIVE_RESET = 1'b1;

	typedef enum logic [2:0] {
		REG_ACTIVE_LEVEL = 3'd0,
		REG_ON_TICKS     = 3'd1,
		REG_OFF_TICKS    = 3'd2,
		REG_BLINKS       = 3'd3,
		REG_GAP_TICKS    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic pin_level;
		logic level_changed;
	} led_result_t;

endpackage

// ===== hdl/led_bpt_regs.sv =====
`timescale 1ns / 1ps

module led_bpt_regs
	import led_bpt_pkg::*;
#(
	parameter int TIME_WIDTH  = 16,
	parameter int COUNT_WIDTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   active_level,
	output logic [TIME_WIDTH-1:0]  on_ticks,
	output logic [TIME_WIDTH-1:0]  off_ticks,
	output logic [COUNT_WIDTH-1:0] blinks_per_burst,
	output logic [TIME_WIDTH-1:0]  gap_ticks,
	output logic                   cfg_clear
);

	logic                   active_q;
	logic [TIME_WIDTH-1:0]  on_q;
	logic [TIME_WIDTH-1:0]  off_q;
	logic [COUNT_WIDTH-1:0] blinks_q;
	logic [TIME_WIDTH-1:0]  gap_q;
	logic                   wr_en;
	reg_idx_t               idx;
	logic [31:0]            time_wr;
	logic [31:0]            count_wr;

	assign idx      = reg_idx_t'(paddr[4:2]);
	assign wr_en    = psel & penable & pwrite;
	// write data is taken from the low 16 and 8 bits, zero-extended, then cut to the configured widths
	assign time_wr  = {16'd0, pwdata[15:0]};
	assign count_wr = {24'd0, pwdata[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
			on_q     <= '0;
			off_q    <= '0;
			blinks_q <= '0;
			gap_q    <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_ACTIVE_LEVEL: active_q <= pwdata[0];
				REG_ON_TICKS:     on_q     <= time_wr[TIME_WIDTH-1:0];
				REG_OFF_TICKS:    off_q    <= time_wr[TIME_WIDTH-1:0];
				REG_BLINKS:       blinks_q <= count_wr[COUNT_WIDTH-1:0];
				REG_GAP_TICKS:    gap_q    <= time_wr[TIME_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ACTIVE_LEVEL: prdata = {31'd0, active_q};
			REG_ON_TICKS:     prdata = 32'(on_q);
			REG_OFF_TICKS:    prdata = 32'(off_q);
			REG_BLINKS:       prdata = 32'(blinks_q);
			REG_GAP_TICKS:    prdata = 32'(gap_q);
			default:          prdata = '0;
		endcase
	end

	// a write beyond the register list clears nothing
	assign cfg_clear = wr_en & (idx <= REG_GAP_TICKS);

	assign active_level     = active_q;
	assign on_ticks         = on_q;
	assign off_ticks        = off_q;
	assign blinks_per_burst = blinks_q;
	assign gap_ticks        = gap_q;

endmodule

// ===== hdl/led_bpt_core.sv =====
`timescale 1ns / 1ps

module led_bpt_core
	import led_bpt_pkg::*;
#(
	parameter int TIME_WIDTH  = 16,
	parameter int COUNT_WIDTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   cfg_clear,
	input  logic                   active_level,
	input  logic [TIME_WIDTH-1:0]  on_ticks,
	input  logic [TIME_WIDTH-1:0]  off_ticks,
	input  logic [COUNT_WIDTH-1:0] blinks_per_burst,
	input  logic [TIME_WIDTH-1:0]  gap_ticks,
	output led_result_t            result,
	output logic                   cur_level
);

	typedef enum logic [1:0] {
		PH_ON    = 2'd0,
		PH_OFF   = 2'd1,
		PH_CHECK = 2'd2,
		PH_GAP   = 2'd3
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [TIME_WIDTH-1:0]  rem_q, rem_n, rem_dec;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n, cnt_inc;
	logic                   wanted_q, wanted_n;
	logic                   driven_q;

	always_comb begin
		rem_dec  = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
		cnt_inc  = cnt_q + 1'b1;
		phase_n  = phase_q;
		rem_n    = rem_dec;
		cnt_n    = cnt_q;
		wanted_n = wanted_q;
		if (rem_dec == '0) begin
			case (phase_q)
				PH_ON: begin
					if (on_ticks != '0) begin
						wanted_n = active_level;
						rem_n    = on_ticks;
						phase_n  = PH_OFF;
					end
				end
				PH_OFF: begin
					if (off_ticks != '0) begin
						wanted_n = ~active_level;
						rem_n    = off_ticks;
						phase_n  = PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_n = PH_ON;
					if (gap_ticks != '0 && blinks_per_burst != '0) begin
						cnt_n = cnt_inc;
						if (cnt_inc >= blinks_per_burst) begin
							rem_n   = gap_ticks;
							phase_n = PH_GAP;
							cnt_n   = '0;
						end
					end
				end
				default: phase_n = PH_ON;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ON;
			rem_q    <= '0;
			cnt_q    <= '0;
			wanted_q <= ~ACTIVE_RESET;
			driven_q <= ~ACTIVE_RESET;
		end else if (cfg_clear) begin
			rem_q <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_n;
			rem_q    <= rem_n;
			cnt_q    <= cnt_n;
			wanted_q <= wanted_n;
			driven_q <= wanted_n;
		end
	end

	assign result.pin_level     = advance ? wanted_n : driven_q;
	assign result.level_changed = advance & (driven_q != wanted_n);
	assign cur_level            = driven_q;

endmodule

// ===== hdl/led_blink_pattern_timer_unit.sv =====
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in       in_valid / in_stall   tick
// out      out_valid / out_stall pin_level, level_changed
// cfg      APB psel/penable      paddr, pwdata, prdata (pready tied high)
//
// One beat in gives one out next cycle; a beat is taken each cycle unless stalled.
// The pattern state updates in the same cycle the tick beat is accepted, unless a write lands.
// in_stall rises only while a result sits in the output register and out_stall is high.
// Reset: LED dark (level 0), phase on, timers and count cleared, active level 1.
// A register write clears the remaining time and blink count.

module led_blink_pattern_timer_unit
	import led_bpt_pkg::*;
#(
	parameter int TIME_WIDTH  = 16,
	parameter int COUNT_WIDTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              tick,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              pin_level,
	output logic              level_changed,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic                   active_level;
	logic [TIME_WIDTH-1:0]  on_ticks;
	logic [TIME_WIDTH-1:0]  off_ticks;
	logic [COUNT_WIDTH-1:0] blinks_per_burst;
	logic [TIME_WIDTH-1:0]  gap_ticks;
	logic                   cfg_clear;
	logic                   in_acc;
	logic                   cur_level;
	led_result_t            result;
	logic                   out_valid_q;
	logic                   pin_level_q;
	logic                   level_changed_q;

	assign pready   = 1'b1;
	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	led_bpt_regs #(
		.TIME_WIDTH (TIME_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.active_level    (active_level),
		.on_ticks        (on_ticks),
		.off_ticks       (off_ticks),
		.blinks_per_burst(blinks_per_burst),
		.gap_ticks       (gap_ticks),
		.cfg_clear       (cfg_clear)
	);

	led_bpt_core #(
		.TIME_WIDTH (TIME_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (in_acc & tick),
		.cfg_clear       (cfg_clear),
		.active_level    (active_level),
		.on_ticks        (on_ticks),
		.off_ticks       (off_ticks),
		.blinks_per_burst(blinks_per_burst),
		.gap_ticks       (gap_ticks),
		.result          (result),
		.cur_level       (cur_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pin_level_q     <= result.pin_level;
			level_changed_q <= result.level_changed;
		end
	end

	assign out_valid     = out_valid_q;
	assign pin_level     = pin_level_q;
	assign level_changed = level_changed_q;

	a_acc_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted tick produced no result beat");

	a_level_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> pin_level_q == cur_level)
		else $error("reported pin level differs from driven level");

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> level_changed_q == (pin_level_q != $past(cur_level)))
		else $error("level_changed disagrees with pin movement");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !tick |=> !level_changed_q)
		else $error("idle tick reported a level change");

endmodule
